@@ rtl/txs_pkg.sv @@
// shared types and constants for the transaction header and field scanner
`timescale 1ns / 1ps
`default_nettype none
package txs_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [60:0] field_number;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic [15:0] payload_offset;
    logic [2:0]  status;
    logic        end_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    PH_VERSION  = 3'd0,
    PH_CHAINLEN = 3'd1,
    PH_CHAIN    = 3'd2,
    PH_NONCE    = 3'd3,
    PH_TAG      = 3'd4,
    PH_VALUE    = 3'd5,
    PH_LENGTH   = 3'd6,
    PH_PAYLOAD  = 3'd7
  } phase_t;

  localparam logic [2:0] REC_HEADER = 3'd0;
  localparam logic [2:0] REC_VARINT = 3'd1;
  localparam logic [2:0] REC_LENGTH = 3'd2;
  localparam logic [2:0] REC_END_OK = 3'd3;
  localparam logic [2:0] REC_ERROR  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUF_END = 3'd1;
  localparam logic [2:0] ST_WIRE    = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_CHARS   = 3'd4;
  localparam logic [2:0] ST_CHAIN   = 3'd5;
  localparam logic [2:0] ST_RANGE   = 3'd6;

  localparam logic [1:0] CFG_VERSION   = 2'd0;
  localparam logic [1:0] CFG_CHAIN_MIN = 2'd1;
  localparam logic [1:0] CFG_CHAIN_MAX = 2'd2;
  localparam logic [1:0] CFG_MIN_TOTAL = 2'd3;

  // scan result for one byte: up to two records
  typedef struct packed {
    logic      two;
    out_word_t first;
    out_word_t second;
  } rec_pair_t;

  function automatic logic chain_char_ok(input logic [7:0] c);
    chain_char_ok = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
                    (c >= 8'h30 && c <= 8'h39) || c == 8'h5f || c == 8'h2e ||
                    c == 8'h2d;
  endfunction

endpackage
`default_nettype wire

@@ rtl/txs_front.sv @@
// front: byte scanner that decodes header and fields into record pairs
`timescale 1ns / 1ps
`default_nettype none
module txs_front #(
  parameter int MAX_BUFFER_BYTES = 65535
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_write,
  input  wire  [1:0]           cfg_index,
  input  wire  [31:0]          cfg_data,
  input  wire                  step,
  input  wire txs_pkg::in_word_t in_word,
  output logic                 emit,
  output txs_pkg::rec_pair_t   pair
);

  logic [31:0] version_word;
  logic [7:0]  chain_len_min;
  logic [7:0]  chain_len_max;
  logic [15:0] min_total_len;

  txs_pkg::phase_t phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [7:0]  chain_length, chain_length_next;
  logic [31:0] version_accumulator, version_accumulator_next;
  logic [63:0] nonce_shift, nonce_shift_next;
  logic [63:0] varint_accumulator, varint_accumulator_next;
  logic [6:0]  varint_shift, varint_shift_next;
  logic [63:0] tag_register, tag_register_next;
  logic [15:0] payload_remaining, payload_remaining_next;
  logic        error_latched, error_latched_next;
  logic [2:0]  error_code, error_code_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      version_word  <= 32'h00feca00;
      chain_len_min <= 8'd1;
      chain_len_max <= 8'd32;
      min_total_len <= 16'd14;
    end else if (cfg_write) begin
      case (cfg_index)
        txs_pkg::CFG_VERSION:   version_word  <= cfg_data;
        txs_pkg::CFG_CHAIN_MIN: chain_len_min <= cfg_data[7:0];
        txs_pkg::CFG_CHAIN_MAX: chain_len_max <= cfg_data[7:0];
        default:                min_total_len <= cfg_data[15:0];
      endcase
    end
  end

  logic [7:0] b;
  logic       have;
  txs_pkg::out_word_t prov;
  logic [63:0] grp_sh;
  logic [63:0] vacc;
  logic        vdone, verr;
  logic [6:0]  vsh;
  logic [2:0]  st;
  logic [15:0] pos_inc;

  always_comb begin
    b = in_word.byte_value;
    phase_next = phase;
    chain_length_next = chain_length;
    version_accumulator_next = version_accumulator;
    nonce_shift_next = nonce_shift;
    varint_accumulator_next = varint_accumulator;
    varint_shift_next = varint_shift;
    tag_register_next = tag_register;
    payload_remaining_next = payload_remaining;
    error_latched_next = error_latched;
    error_code_next = error_code;
    have = 1'b0;
    prov = '0;
    // one varint step
    grp_sh = (varint_shift < 7'd64) ? ({57'd0, b[6:0]} << varint_shift[5:0]) : 64'd0;
    vacc = varint_accumulator | grp_sh;
    vsh = varint_shift + 7'd7;
    vdone = 1'b0;
    verr = 1'b0;
    if (varint_shift == 7'd63 && b[6:1] != 6'd0) begin
      verr = 1'b1;
    end else if (!b[7]) begin
      vdone = 1'b1;
    end else if (vsh >= 7'd64) begin
      verr = 1'b1;
    end
    // per-phase decode
    if (!error_latched) begin
      if ({16'd0, byte_position} >= 32'(MAX_BUFFER_BYTES)) begin
        error_latched_next = 1'b1;
        error_code_next = txs_pkg::ST_BUF_END;
      end else begin
        unique case (phase)
          txs_pkg::PH_VERSION: begin
            version_accumulator_next = version_accumulator |
              ({24'd0, b} << {byte_position[1:0], 3'b000});
            if (byte_position == 16'd3) phase_next = txs_pkg::PH_CHAINLEN;
          end
          txs_pkg::PH_CHAINLEN: begin
            if (b < chain_len_min) begin
              error_latched_next = 1'b1;
              error_code_next = txs_pkg::ST_CHAIN;
            end else if (b > chain_len_max) begin
              error_latched_next = 1'b1;
              error_code_next = txs_pkg::ST_BUF_END;
            end else begin
              chain_length_next = b;
              phase_next = (b != 8'd0) ? txs_pkg::PH_CHAIN : txs_pkg::PH_NONCE;
            end
          end
          txs_pkg::PH_CHAIN: begin
            if (!txs_pkg::chain_char_ok(b)) begin
              error_latched_next = 1'b1;
              error_code_next = txs_pkg::ST_CHARS;
            end else if (byte_position - 16'd4 == {8'd0, chain_length}) begin
              phase_next = txs_pkg::PH_NONCE;
            end
          end
          txs_pkg::PH_NONCE: begin
            nonce_shift_next = {nonce_shift[55:0], b};
            if (byte_position - 16'd5 - {8'd0, chain_length} == 16'd7) begin
              if (version_accumulator != version_word) begin
                error_latched_next = 1'b1;
                error_code_next = txs_pkg::ST_VERSION;
              end else begin
                have = 1'b1;
                prov.record_kind = txs_pkg::REC_HEADER;
                prov.field_value = nonce_shift_next;
                prov.payload_offset = byte_position + 16'd1;
                phase_next = txs_pkg::PH_TAG;
                varint_accumulator_next = '0;
                varint_shift_next = '0;
              end
            end
          end
          txs_pkg::PH_TAG, txs_pkg::PH_VALUE, txs_pkg::PH_LENGTH: begin
            varint_accumulator_next = verr ? varint_accumulator : vacc;
            if (verr) begin
              error_latched_next = 1'b1;
              error_code_next = (varint_shift == 7'd63 && b[6:1] != 6'd0) ?
                                txs_pkg::ST_RANGE : txs_pkg::ST_BUF_END;
              if (!(varint_shift == 7'd63 && b[6:1] != 6'd0))
                varint_accumulator_next = vacc;
              varint_shift_next = vsh;
            end else if (!vdone) begin
              varint_shift_next = vsh;
            end else begin
              varint_accumulator_next = '0;
              varint_shift_next = '0;
              if (phase == txs_pkg::PH_TAG) begin
                tag_register_next = vacc;
                if (vacc[2:0] == 3'd0) phase_next = txs_pkg::PH_VALUE;
                else if (vacc[2:0] == 3'd2) phase_next = txs_pkg::PH_LENGTH;
                else begin
                  error_latched_next = 1'b1;
                  error_code_next = txs_pkg::ST_WIRE;
                end
              end else if (phase == txs_pkg::PH_VALUE) begin
                have = 1'b1;
                prov.record_kind = txs_pkg::REC_VARINT;
                prov.field_number = tag_register[63:3];
                prov.field_value = vacc;
                phase_next = txs_pkg::PH_TAG;
              end else if (vacc >= 64'd65535) begin
                varint_accumulator_next = vacc;
                error_latched_next = 1'b1;
                error_code_next = txs_pkg::ST_RANGE;
              end else begin
                payload_remaining_next = vacc[15:0];
                have = 1'b1;
                prov.record_kind = txs_pkg::REC_LENGTH;
                prov.field_number = tag_register[63:3];
                prov.wire_kind = 3'd2;
                prov.field_value = vacc;
                prov.payload_offset = byte_position + 16'd1;
                phase_next = (vacc[15:0] != 16'd0) ? txs_pkg::PH_PAYLOAD :
                             txs_pkg::PH_TAG;
              end
            end
          end
          default: begin
            if (payload_remaining != 16'd0)
              payload_remaining_next = payload_remaining - 16'd1;
            if (payload_remaining_next == 16'd0) phase_next = txs_pkg::PH_TAG;
          end
        endcase
      end
    end
    pos_inc = (byte_position != 16'hffff) ? byte_position + 16'd1 : byte_position;
    byte_position_next = pos_inc;
    // final status
    if (pos_inc < min_total_len) st = txs_pkg::ST_BUF_END;
    else if (error_latched_next) st = error_code_next;
    else if (phase_next == txs_pkg::PH_TAG) st = txs_pkg::ST_OK;
    else st = txs_pkg::ST_BUF_END;
    pair = '0;
    emit = 1'b0;
    if (in_word.last_byte) begin
      emit = 1'b1;
      if (st == txs_pkg::ST_OK) begin
        pair.first = prov;
        pair.second.record_kind = txs_pkg::REC_END_OK;
        pair.second.end_of_run = 1'b1;
        pair.two = have;
        if (!have) pair.first = pair.second;
      end else begin
        pair.first.record_kind = txs_pkg::REC_ERROR;
        pair.first.status = st;
        pair.first.end_of_run = 1'b1;
      end
    end else if (have) begin
      emit = 1'b1;
      pair.first = prov;
    end
  end

  // scan state; cleared after every final byte
  always_ff @(posedge clk) begin
    if (rst || (step && in_word.last_byte)) begin
      phase <= txs_pkg::PH_VERSION;
      byte_position <= '0;
      chain_length <= '0;
      version_accumulator <= '0;
      nonce_shift <= '0;
      varint_accumulator <= '0;
      varint_shift <= '0;
      tag_register <= '0;
      payload_remaining <= '0;
      error_latched <= 1'b0;
      error_code <= '0;
    end else if (step) begin
      phase <= phase_next;
      byte_position <= byte_position_next;
      chain_length <= chain_length_next;
      version_accumulator <= version_accumulator_next;
      nonce_shift <= nonce_shift_next;
      varint_accumulator <= varint_accumulator_next;
      varint_shift <= varint_shift_next;
      tag_register <= tag_register_next;
      payload_remaining <= payload_remaining_next;
      error_latched <= error_latched_next;
      error_code <= error_code_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/txs_queue.sv @@
// back: two-entry queue of record pairs, drained one word at a time
`timescale 1ns / 1ps
`default_nettype none
module txs_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire txs_pkg::rec_pair_t push_pair,
  output logic                 space,
  output logic                 out_valid,
  input  wire                  out_ready,
  output txs_pkg::out_word_t   out_data
);

  txs_pkg::rec_pair_t slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       half;
  logic       pop;

  assign space = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data = half ? slot[rd_ptr].second : slot[rd_ptr].first;
  assign pop = out_valid && out_ready && (half || !slot[rd_ptr].two);

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
      half <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) half <= pop ? 1'b0 : 1'b1;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_pair;
  end

endmodule
`default_nettype wire

@@ rtl/tx_header_and_varint_field_scanner.sv @@
// a record is registered in the record queue before it appears at the output
// throughput: one byte per cycle while the record queue has space; the byte scanner is combinational
// a byte giving two records fills one entry of the two-entry record queue and drains as two output words
// reset: synchronous, active high; clears scan state, queue and restores config defaults
// scan state also returns to reset after every final byte
`timescale 1ns / 1ps
`default_nettype none
module tx_header_and_varint_field_scanner #(
  parameter int MAX_BUFFER_BYTES = 65535
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire txs_pkg::in_word_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output txs_pkg::out_word_t  out_data,
  input  wire                 cfg_write,
  input  wire  [1:0]          cfg_index,
  input  wire  [31:0]         cfg_data
);

  logic step, emit;
  txs_pkg::rec_pair_t pair;
  logic space;

  assign in_ready = space;
  assign step = in_valid && in_ready;

  txs_front #(.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)) u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .step, .in_word(in_data), .emit, .pair
  );

  txs_queue u_queue (
    .clk, .rst, .push(step && emit), .push_pair(pair), .space,
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

@@ rtl/txs_checker.sv @@
// port-level checks for the scanner, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module txs_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire txs_pkg::out_word_t out_data
);

  // final records carry the end mark
  a_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.end_of_run == (out_data.record_kind == txs_pkg::REC_END_OK ||
                   out_data.record_kind == txs_pkg::REC_ERROR)))
    else $error("end mark mismatch");

  // error words carry a nonzero status
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.record_kind == txs_pkg::REC_ERROR |->
      out_data.status != txs_pkg::ST_OK)
    else $error("error without status");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // input is only refused while words wait at the output
  a_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid)
    else $error("input refused with empty output");

  // no output word is valid just after reset
  a_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output after reset");

endmodule

bind tx_header_and_varint_field_scanner txs_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

@@ verif/tx_header_and_varint_field_scanner_chk.sv @@
// checker: predicts scanner records from accepted bytes and compares them
`timescale 1ns / 1ps
module tx_header_and_varint_field_scanner_chk (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  txs_pkg::in_word_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  txs_pkg::out_word_t  out_data,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);

  localparam int BUF_LIMIT = 65535;

  // configuration copy
  logic [31:0] ver_word;
  logic [7:0]  chain_min, chain_max;
  logic [15:0] total_min;

  // scan state copy
  txs_pkg::phase_t ph;
  logic [15:0] pos_q;
  logic [7:0]  chain_len;
  logic [31:0] ver_acc;
  logic [63:0] nonce_q;
  logic [63:0] vacc;
  logic [6:0]  vshift;
  logic [63:0] tag_q;
  logic [15:0] remain;
  logic        err_set;
  logic [2:0]  err_code;

  txs_pkg::out_word_t record_queue[$];

  assign pending = record_queue.size();

  function automatic txs_pkg::out_word_t mk_rec(logic [2:0] kind, logic [60:0] fnum,
                                                logic [2:0] wire_t, logic [63:0] val,
                                                logic [15:0] off, logic [2:0] st,
                                                logic eor);
    txs_pkg::out_word_t r;
    r.record_kind = kind;
    r.field_number = fnum;
    r.wire_kind = wire_t;
    r.field_value = val;
    r.payload_offset = off;
    r.status = st;
    r.end_of_run = eor;
    return r;
  endfunction

  task automatic clear_scan();
    ph = txs_pkg::PH_VERSION;
    pos_q = '0;
    chain_len = '0;
    ver_acc = '0;
    nonce_q = '0;
    vacc = '0;
    vshift = '0;
    tag_q = '0;
    remain = '0;
    err_set = 1'b0;
    err_code = txs_pkg::ST_OK;
  endtask

  function automatic void raise(logic [2:0] code);
    if (!err_set) begin
      err_set = 1'b1;
      err_code = code;
    end
  endfunction

  // varint byte: 1 done, 0 more, -1 error
  function automatic int feed_varint(logic [7:0] b);
    logic [63:0] grp;
    grp = {57'd0, b[6:0]};
    if (vshift == 7'd63 && grp > 64'd1) begin
      raise(txs_pkg::ST_RANGE);
      return -1;
    end
    if (vshift < 7'd64) vacc = vacc | (grp << vshift);
    if (!b[7]) return 1;
    vshift = vshift + 7'd7;
    if (vshift >= 7'd64) begin
      raise(txs_pkg::ST_BUF_END);
      return -1;
    end
    return 0;
  endfunction

  task automatic scan_byte(logic [7:0] b, logic last);
    logic [15:0] p;
    logic        have;
    txs_pkg::out_word_t prov;
    logic [2:0]  st;
    int          r;
    p = pos_q;
    have = 1'b0;
    prov = '0;
    if (!err_set) begin
      if (p >= BUF_LIMIT) raise(txs_pkg::ST_BUF_END);
      else begin
        case (ph)
          txs_pkg::PH_VERSION: begin
            ver_acc = ver_acc | (32'(b) << (8 * p[1:0]));
            if (p == 16'd3) ph = txs_pkg::PH_CHAINLEN;
          end
          txs_pkg::PH_CHAINLEN: begin
            if (b < chain_min) raise(txs_pkg::ST_CHAIN);
            else if (b > chain_max) raise(txs_pkg::ST_BUF_END);
            else begin
              chain_len = b;
              ph = (b != 8'd0) ? txs_pkg::PH_CHAIN : txs_pkg::PH_NONCE;
            end
          end
          txs_pkg::PH_CHAIN: begin
            if (!((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9")
                  || b == "_" || b == "." || b == "-"))
              raise(txs_pkg::ST_CHARS);
            else if (16'(p - 16'd4) == {8'd0, chain_len}) ph = txs_pkg::PH_NONCE;
          end
          txs_pkg::PH_NONCE: begin
            nonce_q = {nonce_q[55:0], b};
            if (16'(p - 16'd5 - chain_len) == 16'd7) begin
              if (ver_acc != ver_word) raise(txs_pkg::ST_VERSION);
              else begin
                have = 1'b1;
                prov = mk_rec(txs_pkg::REC_HEADER, '0, '0, nonce_q, p + 16'd1,
                              txs_pkg::ST_OK, 1'b0);
                ph = txs_pkg::PH_TAG;
                vacc = '0;
                vshift = '0;
              end
            end
          end
          txs_pkg::PH_TAG: begin
            r = feed_varint(b);
            if (r == 1) begin
              tag_q = vacc;
              vacc = '0;
              vshift = '0;
              if (tag_q[2:0] == 3'd0) ph = txs_pkg::PH_VALUE;
              else if (tag_q[2:0] == 3'd2) ph = txs_pkg::PH_LENGTH;
              else raise(txs_pkg::ST_WIRE);
            end
          end
          txs_pkg::PH_VALUE: begin
            r = feed_varint(b);
            if (r == 1) begin
              have = 1'b1;
              prov = mk_rec(txs_pkg::REC_VARINT, tag_q[63:3], 3'd0, vacc, 16'd0,
                            txs_pkg::ST_OK, 1'b0);
              vacc = '0;
              vshift = '0;
              ph = txs_pkg::PH_TAG;
            end
          end
          txs_pkg::PH_LENGTH: begin
            r = feed_varint(b);
            if (r == 1) begin
              if (vacc >= 64'd65535) raise(txs_pkg::ST_RANGE);
              else begin
                remain = vacc[15:0];
                have = 1'b1;
                prov = mk_rec(txs_pkg::REC_LENGTH, tag_q[63:3], 3'd2, vacc, p + 16'd1,
                              txs_pkg::ST_OK, 1'b0);
                vacc = '0;
                vshift = '0;
                ph = (remain != 16'd0) ? txs_pkg::PH_PAYLOAD : txs_pkg::PH_TAG;
              end
            end
          end
          default: begin
            if (remain != 16'd0) remain = remain - 16'd1;
            if (remain == 16'd0) ph = txs_pkg::PH_TAG;
          end
        endcase
      end
    end
    if (pos_q < 16'hFFFF) pos_q = pos_q + 16'd1;
    if (last) begin
      if (pos_q < total_min) st = txs_pkg::ST_BUF_END;
      else if (err_set) st = err_code;
      else if (ph == txs_pkg::PH_TAG) st = txs_pkg::ST_OK;
      else st = txs_pkg::ST_BUF_END;
      if (st == txs_pkg::ST_OK) begin
        if (have) record_queue.push_back(prov);
        record_queue.push_back(mk_rec(txs_pkg::REC_END_OK, '0, '0, '0, '0,
                                      txs_pkg::ST_OK, 1'b1));
      end else begin
        record_queue.push_back(mk_rec(txs_pkg::REC_ERROR, '0, '0, '0, '0, st, 1'b1));
      end
      clear_scan();
    end else if (have) begin
      record_queue.push_back(prov);
    end
  endtask

  task automatic check_word(txs_pkg::out_word_t got);
    txs_pkg::out_word_t want;
    if (record_queue.size() == 0) begin
      $error("unexpected word kind=%0d status=%0d", got.record_kind, got.status);
      fail_count++;
      return;
    end
    want = record_queue.pop_front();
    if (got.record_kind !== want.record_kind) begin
      $error("record_kind exp %0d got %0d", want.record_kind, got.record_kind); fail_count++;
    end
    if (got.field_number !== want.field_number) begin
      $error("field_number exp %0h got %0h", want.field_number, got.field_number); fail_count++;
    end
    if (got.wire_kind !== want.wire_kind) begin
      $error("wire_kind exp %0d got %0d", want.wire_kind, got.wire_kind); fail_count++;
    end
    if (got.field_value !== want.field_value) begin
      $error("field_value exp %0h got %0h", want.field_value, got.field_value); fail_count++;
    end
    if (got.payload_offset !== want.payload_offset) begin
      $error("payload_offset exp %0d got %0d", want.payload_offset, got.payload_offset);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $error("status exp %0d got %0d", want.status, got.status); fail_count++;
    end
    if (got.end_of_run !== want.end_of_run) begin
      $error("end_of_run exp %0d got %0d", want.end_of_run, got.end_of_run); fail_count++;
    end
  endtask

  initial fail_count = 0;

  // track config writes, bytes and records at each edge
  always @(posedge clk) begin
    if (rst) begin
      ver_word = 32'h00FECA00;
      chain_min = 8'd1;
      chain_max = 8'd32;
      total_min = 16'd14;
      clear_scan();
      record_queue.delete();
    end else begin
      if (out_valid && out_ready) check_word(out_data);
      if (cfg_write) begin
        case (cfg_index)
          txs_pkg::CFG_VERSION:   ver_word = cfg_data;
          txs_pkg::CFG_CHAIN_MIN: chain_min = cfg_data[7:0];
          txs_pkg::CFG_CHAIN_MAX: chain_max = cfg_data[7:0];
          default:                total_min = cfg_data[15:0];
        endcase
      end
      if (in_valid && in_ready) scan_byte(in_data.byte_value, in_data.last_byte);
    end
  end
endmodule

@@ verif/tx_header_and_varint_field_scanner_tb.sv @@
// testbench top: byte stream stimulus, config phases and verdict
`timescale 1ns / 1ps
module tx_header_and_varint_field_scanner_tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  txs_pkg::in_word_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  txs_pkg::out_word_t out_data;
  logic        cfg_write = 0;
  logic [1:0]  cfg_index = txs_pkg::CFG_VERSION;
  logic [31:0] cfg_data = 0;
  int          fail_count;
  int          pending;
  int          bytes_sent = 0;
  int          idle_cycles = 0;
  logic        calm = 0;
  logic        done = 0;

  // stimulus-side copy of the config, used only to build sensible transactions
  logic [31:0] cur_ver = 32'h00FECA00;
  logic [7:0]  cur_min = 1, cur_max = 32;

  always #5 clk = ~clk;

  tx_header_and_varint_field_scanner uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tx_header_and_varint_field_scanner_chk chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      n = $urandom_range(1, 24);
      repeat (n) @(posedge clk);
    end
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles > 5000) begin
      $display("tx_header_and_varint_field_scanner: mismatch");
      $finish;
    end
  end

  // valid stays up after acceptance; the next byte, an idle gap or drain replaces it
  task automatic send_byte(logic [7:0] b, logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{byte_value: b, last_byte: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] chain_char();
    logic [7:0] set[$];
    set = '{"a", "z", "A", "Z", "0", "9", "_", ".", "-", "m", "Q", "5"};
    return set[$urandom_range(0, set.size() - 1)];
  endfunction

  task automatic send_varint(logic [63:0] v, logic last_at_end);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1;
      send_byte(b, last_at_end && v == 0);
    end while (v != 0);
  endtask

  // one transaction; flaw selects a corruption (0 = well-formed)
  task automatic send_tx(int flaw, int nfields);
    logic [31:0] ver;
    int          clen;
    logic [63:0] tag, val;
    int          plen, k, len_range;
    ver = (flaw == 1) ? cur_ver ^ (32'd1 << $urandom_range(0, 31)) : cur_ver;
    for (int i = 0; i < 4; i++) send_byte(ver[8*i +: 8], 0);
    len_range = cur_max - cur_min;
    clen = cur_min + $urandom_range(0, len_range > 6 ? 6 : len_range);
    if (flaw == 2) clen = (cur_min > 0) ? cur_min - 1 : cur_max + 1;
    if (flaw == 3 && cur_max < 255) clen = cur_max + 1;
    send_byte(clen[7:0], 0);
    for (int i = 0; i < clen; i++)
      send_byte((flaw == 4 && i == clen - 1) ? 8'($urandom_range(0, 8'h2c)) : chain_char(), 0);
    // cut inside the nonce ends the transaction there
    for (int i = 0; i < 8; i++) begin
      val = {$urandom, $urandom};
      send_byte(val[7:0], flaw == 5 && i == 3);
      if (flaw == 5 && i == 3) return;
    end
    for (int f = 0; f < nfields; f++) begin
      tag = {$urandom, $urandom} >> $urandom_range(3, 63);
      tag[2:0] = $urandom_range(0, 1) ? 3'd0 : 3'd2;
      if (flaw == 6 && f == nfields - 1) tag[2:0] = 3'($urandom_range(0, 2) * 2 + 1);
      send_varint(tag, 0);
      if (tag[2:0] == 0) begin
        val = {$urandom, $urandom} >> $urandom_range(0, 63);
        if (flaw == 7 && f == nfields - 1) begin
          for (int i = 0; i < 9; i++) send_byte(8'hff, 0);
          send_byte($urandom_range(0, 1) ? 8'h81 : 8'(2 + $urandom_range(0, 125)), 0);
        end else send_varint(val, 0);
      end else begin
        plen = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        if (flaw == 8 && f == nfields - 1) plen = 65535 + $urandom_range(0, 3);
        send_varint(64'(plen), 0);
        if (plen < 65535)
          for (k = 0; k < plen; k++) begin
            send_byte(8'($urandom), flaw == 9 && k == plen / 2);
            if (flaw == 9 && k == plen / 2) return;
          end
      end
    end
    // close: a one-byte varint field ends cleanly, or cut mid-varint
    if (flaw == 10) send_byte(8'h80 | 8'($urandom), 1);
    else begin
      send_byte(8'h08, 0);
      send_byte(8'($urandom_range(0, 127)), 1);
    end
  endtask

  initial begin
    int flaw;
    int phase_start;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, each special case but the payload cut (flaw 9)
    send_tx(0, 2);
    send_tx(1, 1);
    send_tx(2, 1);
    send_tx(3, 1);
    send_tx(4, 1);
    send_tx(5, 0);
    send_tx(6, 1);
    send_tx(7, 1);
    send_tx(8, 1);
    send_tx(10, 1);
    send_byte(8'h00, 1);               // too short
    for (int i = 0; i < 3; i++) send_byte(8'hff, 0);
    send_byte(8'h00, 1);               // short, ends on the last version byte
    // zero-length chain id, field number 0
    cur_min = 0;
    drain();
    write_cfg(txs_pkg::CFG_CHAIN_MIN, 0);
    for (int i = 0; i < 4; i++) send_byte(cur_ver[8*i +: 8], 0);
    send_byte(8'h00, 0);
    for (int i = 0; i < 8; i++) send_byte(8'hff, 0);
    send_byte(8'h00, 0);
    send_byte(8'hff, 0);
    send_byte(8'hff, 1);               // ends inside a varint
    drain();

    // random phases through several settings
    for (int phase_n = 0; phase_n < 6; phase_n++) begin
      case (phase_n)
        0: begin cur_ver = 32'h00FECA00; cur_min = 1; cur_max = 32; end
        1: begin cur_ver = 32'hFFFFFFFF; cur_min = 0; cur_max = 255; end
        2: begin cur_ver = 32'h0; cur_min = 255; cur_max = 255; end
        3: begin cur_ver = $urandom; cur_min = 3; cur_max = 3; end
        4: begin cur_ver = $urandom; cur_min = 0; cur_max = 0; end
        default: begin cur_ver = 32'h00FECA00; cur_min = 1; cur_max = 32; end
      endcase
      write_cfg(txs_pkg::CFG_VERSION, cur_ver);
      write_cfg(txs_pkg::CFG_CHAIN_MIN, {24'($urandom_range(0, 16777215)), cur_min});
      write_cfg(txs_pkg::CFG_CHAIN_MAX, {24'($urandom_range(0, 16777215)), cur_max});
      write_cfg(txs_pkg::CFG_MIN_TOTAL, phase_n == 2 ? 32'hFFFF : phase_n == 4 ? 0 : 14);
      calm = (phase_n == 5);
      phase_start = bytes_sent;
      // a full-length chain id is long, so that setting gets one transaction
      if (phase_n == 2) send_tx(0, 1);
      else begin
        while (bytes_sent - phase_start < 260) begin
          flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
          send_tx(flaw, $urandom_range(0, 4));
        end
      end
      drain();
    end

    done = 1;
    if (fail_count == 0) $display("tx_header_and_varint_field_scanner: match");
    else $display("tx_header_and_varint_field_scanner: mismatch");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/txs_pkg.sv
rtl/txs_front.sv
rtl/txs_queue.sv
rtl/tx_header_and_varint_field_scanner.sv
rtl/txs_checker.sv
verif/tx_header_and_varint_field_scanner_chk.sv
verif/tx_header_and_varint_field_scanner_tb.sv
